>>> sv/pll_pkg.sv
package pll_pkg;

  localparam int CMD_W = 2;
  localparam int POS_W = 7;
  localparam int DATA_W = 32;
  localparam int CNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] new_value;
  } pll_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         item_position;
    logic [CNT_W-1:0]         node_count;
    logic                     last;
  } pll_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture command, start walk at head
    logic step;      // follow forward link of cursor
    logic link_ins;  // splice new node before cursor
    logic link_del;  // unlink cursor node
    logic emit;      // load output register
    logic [1:0] st;
    logic zero_val;
    logic dump_pos;
  } pll_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             cnt_is_k;   // cursor is at the last node (k+1 equals length)
    logic             walk_done;  // cursor reached target position
    logic             out_busy;
  } pll_sts_t;

endpackage

>>> sv/pll_ctrl.sv
module pll_ctrl import pll_pkg::*; #(
  parameter int CNT_BITS = 5
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  pll_sts_t sts,
  input  logic [CNT_BITS-1:0] length,
  output pll_ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_WALK = 5'b00100,
    S_DUMP = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [POS_W:0] lenx;
  logic pos_ok_ins, pos_ok_del;

  assign lenx = (POS_W+1)'(length);
  assign pos_ok_ins = (sts.position != '0) && ({1'b0, sts.position} <= lenx + 1'b1);
  assign pos_ok_del = (sts.position != '0) && ({1'b0, sts.position} <= lenx);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.out_busy) begin
          case (sts.cmd)
            CMD_INSERT: begin
              if (!pos_ok_ins) begin
                ctl.emit = 1'b1; ctl.st = ST_BADPOS; ctl.zero_val = 1'b1;
                state_next = S_IDLE;
              end else if (sts.full) begin
                ctl.emit = 1'b1; ctl.st = ST_FULL; ctl.zero_val = 1'b1;
                state_next = S_IDLE;
              end else state_next = S_WALK;
            end
            CMD_DELETE: begin
              if (sts.empty) begin
                ctl.emit = 1'b1; ctl.st = ST_EMPTY; ctl.zero_val = 1'b1;
                state_next = S_IDLE;
              end else if (!pos_ok_del) begin
                ctl.emit = 1'b1; ctl.st = ST_BADPOS; ctl.zero_val = 1'b1;
                state_next = S_IDLE;
              end else state_next = S_WALK;
            end
            CMD_DUMP: begin
              if (sts.empty) begin
                ctl.emit = 1'b1; ctl.st = ST_EMPTY; ctl.zero_val = 1'b1;
                ctl.dump_pos = 1'b1;
                state_next = S_IDLE;
              end else state_next = S_DUMP;
            end
            default: begin
              ctl.emit = 1'b1; ctl.st = ST_BADPOS; ctl.zero_val = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (sts.walk_done) state_next = S_FIN;
        else ctl.step = 1'b1;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          ctl.emit = 1'b1;
          ctl.st = ST_OK;
          if (sts.cmd == CMD_INSERT) begin
            ctl.link_ins = 1'b1; ctl.zero_val = 1'b1;
          end else ctl.link_del = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (!sts.out_busy) begin
          ctl.emit = 1'b1; ctl.st = ST_OK; ctl.dump_pos = 1'b1;
          ctl.step = 1'b1;
          if (sts.cnt_is_k) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/pll_dp.sv
module pll_dp import pll_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_BITS = $clog2(CAPACITY + 1),
  parameter int CNT_BITS = $clog2(CAPACITY + 1)
) (
  input  logic     clk,
  input  logic     rst,
  input  pll_in_t  in_item,
  input  pll_ctl_t ctl,
  output pll_sts_t sts,
  output logic [CNT_BITS-1:0] length,
  output logic     out_valid,
  input  logic     out_stall,
  output pll_out_t out_item
);

  localparam logic [IDX_BITS-1:0] NIL = IDX_BITS'(CAPACITY);
  localparam int SLOT_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // node stores: small, read at the cursor only
  logic [VALUE_WIDTH-1:0] vals [CAPACITY];
  logic [IDX_BITS-1:0]    fwd  [CAPACITY];
  logic [IDX_BITS-1:0]    bwd  [CAPACITY];
  logic [CAPACITY-1:0]    used;
  logic [IDX_BITS-1:0]    head, tail;

  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [VALUE_WIDTH-1:0] nval;
  logic [IDX_BITS-1:0] cur, prv;   // cursor and its predecessor
  logic [POS_W-1:0]    k;          // number of nodes passed so far

  logic [SLOT_BITS-1:0] free_s;
  logic [SLOT_BITS-1:0] cur_s, prv_s;
  logic [IDX_BITS-1:0]  cur_fwd, cur_bwd;
  logic [VALUE_WIDTH-1:0] cur_val;
  logic [POS_W-1:0] target;

  assign cur_s = cur[SLOT_BITS-1:0];
  assign prv_s = prv[SLOT_BITS-1:0];
  assign cur_fwd = (cur == NIL) ? NIL : fwd[cur_s];
  assign cur_bwd = bwd[cur_s];
  assign cur_val = vals[cur_s];

  always_comb begin
    free_s = '0;
    for (int i = CAPACITY - 1; i >= 0; i--)
      if (!used[i]) free_s = SLOT_BITS'(i);
  end

  // insert stops with cur at the node now at position, delete on it
  assign target = position - 1'b1;

  always_comb begin
    sts = '0;
    sts.position = position;
    sts.cmd = cmd;
    sts.empty = (length == '0);
    sts.full = (length == CNT_BITS'(CAPACITY));
    sts.cnt_is_k = ((POS_W+1)'(k) + 1'b1 == (POS_W+1)'(length));
    sts.walk_done = (k == target);
    sts.out_busy = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= in_item.cmd;
      position <= in_item.position;
      nval <= VALUE_WIDTH'(in_item.new_value);
    end
    if (ctl.load) begin
      cur <= head; prv <= NIL; k <= '0;
    end else if (ctl.step) begin
      prv <= cur; cur <= cur_fwd; k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.link_ins) begin
      vals[free_s] <= nval;
      fwd[free_s] <= cur;
      bwd[free_s] <= prv;
      if (prv != NIL) fwd[prv_s] <= IDX_BITS'(free_s);
      if (cur != NIL) bwd[cur_s] <= IDX_BITS'(free_s);
    end
    if (ctl.link_del) begin
      if (cur_bwd != NIL) fwd[cur_bwd[SLOT_BITS-1:0]] <= cur_fwd;
      if (cur_fwd != NIL) bwd[cur_fwd[SLOT_BITS-1:0]] <= cur_bwd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0; head <= NIL; tail <= NIL; length <= '0;
    end else if (ctl.link_ins) begin
      used[free_s] <= 1'b1;
      length <= length + 1'b1;
      if (prv == NIL) head <= IDX_BITS'(free_s);
      if (cur == NIL) tail <= IDX_BITS'(free_s);
    end else if (ctl.link_del) begin
      used[cur_s] <= 1'b0;
      length <= length - 1'b1;
      if (cur_bwd == NIL) head <= cur_fwd;
      if (cur_fwd == NIL) tail <= cur_bwd;
    end
  end

  // output register; count reflects the list after this command
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.emit) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_item.status <= ctl.st;
      out_item.item_value <= ctl.zero_val ? '0 : DATA_W'($signed(cur_val));
      out_item.item_position <= ctl.dump_pos ?
          (ctl.zero_val ? '0 : k + 1'b1) : position;
      out_item.node_count <= ctl.link_ins ? CNT_W'(length + 1'b1) :
                             ctl.link_del ? CNT_W'(length - 1'b1) : CNT_W'(length);
      out_item.last <= !(ctl.step && ctl.dump_pos && !sts.cnt_is_k);
    end
  end

endmodule

>>> sv/positional_linked_list_engine.sv
// Positional doubly linked list engine.
// Input channel in_item/in_valid/in_stall carries commands (insert at a
// 1-based position, delete at a position, dump the list). Output channel
// out_item/out_valid/out_stall carries results: one per insert or delete,
// one per element for dump (one if empty), with last set on the final one.
// One command is worked at a time; in_stall stays high until it is done.
// Insert/delete walk the forward links one node per cycle from the head, and
// dump emits one element per cycle unless a held result stalls the output.
// The link walk sets the rate.
// Result transfers go through one output register; while out_stall holds,
// the controller waits and the held result does not change.
// Reset (rst, synchronous) empties the list: head and tail go to null,
// the used map and the count clear. Node stores need no clearing.
module positional_linked_list_engine import pll_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  pll_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output pll_out_t out_item
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  pll_ctl_t ctl;
  pll_sts_t sts;
  logic [CNT_BITS-1:0] length;

  pll_ctrl #(.CNT_BITS(CNT_BITS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .sts, .length, .ctl
  );

  pll_dp #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH),
           .CNT_BITS(CNT_BITS)) u_dp (
    .clk, .rst, .in_item, .ctl, .sts, .length,
    .out_valid, .out_stall, .out_item
  );

  a_len_max: assert property (@(posedge clk) disable iff (rst)
    length <= CNT_BITS'(CAPACITY)) else $error("length above capacity");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !ctl.emit) else $error("held result overwritten");
  a_one_edit: assert property (@(posedge clk) disable iff (rst)
    !(ctl.link_ins && ctl.link_del)) else $error("insert and delete together");

endmodule

>>> verif/positional_linked_list_engine_test.sv
module positional_linked_list_engine_test;
  import pll_pkg::*;

  localparam int CAP = 16;
  localparam int LIMIT = 400000;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pll_in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pll_out_t out_item;

  positional_linked_list_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: list kept as an ordered array of values
  logic signed [DATA_W-1:0] list_vals[$];
  pll_out_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int send_idle_pct = 24;
  int recv_idle_pct = 61;
  int hold_off = 0;

  function automatic pll_out_t mk(logic [1:0] st, logic signed [DATA_W-1:0] v,
                                  logic [POS_W-1:0] p, logic lst);
    pll_out_t r;
    r.status = st;
    r.item_value = v;
    r.item_position = p;
    r.node_count = CNT_W'(list_vals.size());
    r.last = lst;
    return r;
  endfunction

  task automatic predict_list(input pll_in_t c);
    int n;
    int p;
    n = list_vals.size();
    p = c.position;
    case (c.cmd)
      CMD_INSERT: begin
        if (p < 1 || p > n + 1) pending_results.push_back(mk(ST_BADPOS, 0, c.position, 1'b1));
        else if (n >= CAP) pending_results.push_back(mk(ST_FULL, 0, c.position, 1'b1));
        else begin
          list_vals.insert(p - 1, c.new_value);
          pending_results.push_back(mk(ST_OK, 0, c.position, 1'b1));
        end
      end
      CMD_DELETE: begin
        if (n == 0) pending_results.push_back(mk(ST_EMPTY, 0, c.position, 1'b1));
        else if (p < 1 || p > n) pending_results.push_back(mk(ST_BADPOS, 0, c.position, 1'b1));
        else begin
          logic signed [DATA_W-1:0] v;
          v = list_vals[p - 1];
          list_vals.delete(p - 1);
          pending_results.push_back(mk(ST_OK, v, c.position, 1'b1));
        end
      end
      CMD_DUMP: begin
        if (n == 0) pending_results.push_back(mk(ST_EMPTY, 0, '0, 1'b1));
        else
          for (int k = 0; k < n; k++)
            pending_results.push_back(mk(ST_OK, list_vals[k], POS_W'(k + 1), k == n - 1));
      end
      default: pending_results.push_back(mk(ST_BADPOS, 0, c.position, 1'b1));
    endcase
  endtask

  // directed table: cmd, position, value, typed result when obvious
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [DATA_W-1:0] val;
    logic typed;
    logic [1:0] st;
  } step_row_t;

  step_row_t directed_steps[] = '{
    '{CMD_DUMP,   7'd0,   32'h0,        1'b1, ST_EMPTY},
    '{CMD_DELETE, 7'd1,   32'h0,        1'b1, ST_EMPTY},
    '{CMD_DELETE, 7'd127, 32'h0,        1'b1, ST_EMPTY},
    '{CMD_INSERT, 7'd0,   32'h5,        1'b1, ST_BADPOS},
    '{CMD_INSERT, 7'd2,   32'h5,        1'b1, ST_BADPOS},
    '{CMD_INSERT, 7'd1,   32'h80000000, 1'b1, ST_OK},
    '{CMD_INSERT, 7'd2,   32'h7fffffff, 1'b1, ST_OK},
    '{CMD_INSERT, 7'd1,   32'hffffffff, 1'b1, ST_OK},
    '{CMD_INSERT, 7'd2,   32'h00000000, 1'b1, ST_OK},
    '{CMD_INSERT, 7'd127, 32'h1,        1'b1, ST_BADPOS},
    '{CMD_SPARE,  7'd99,  32'h1,        1'b1, ST_BADPOS},
    '{CMD_DUMP,   7'd127, 32'hffffffff, 1'b0, ST_OK},
    '{CMD_DELETE, 7'd0,   32'h0,        1'b1, ST_BADPOS},
    '{CMD_DELETE, 7'd5,   32'h0,        1'b1, ST_BADPOS},
    '{CMD_DELETE, 7'd4,   32'h0,        1'b0, ST_OK},
    '{CMD_DELETE, 7'd1,   32'h0,        1'b0, ST_OK},
    '{CMD_DELETE, 7'd2,   32'h0,        1'b0, ST_OK},
    '{CMD_DUMP,   7'd0,   32'h0,        1'b0, ST_OK},
    '{CMD_DELETE, 7'd1,   32'h0,        1'b0, ST_OK},
    '{CMD_DUMP,   7'd0,   32'h0,        1'b1, ST_EMPTY}
  };

  // valid stays high after a transfer until the next command or idle cycle
  task automatic send_cmd(input pll_in_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    predict_list(c);
    in_item <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic pll_in_t rand_cmd();
    pll_in_t c;
    int n;
    int r;
    n = list_vals.size();
    r = $urandom_range(99);
    c.new_value = $urandom;
    if (r < 45) begin
      c.cmd = CMD_INSERT;
      c.position = POS_W'($urandom_range(n + 1, 1));
    end else if (r < 80) begin
      c.cmd = CMD_DELETE;
      c.position = POS_W'($urandom_range(n > 0 ? n : 1, 1));
    end else if (r < 88) begin
      c.cmd = CMD_DUMP;
      c.position = POS_W'($urandom);
    end else begin
      c.cmd = CMD_W'($urandom);
      c.position = POS_W'($urandom);
    end
    return c;
  endfunction

  // receiver: random stall plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        errors++;
      end else begin
        pll_out_t e;
        e = pending_results.pop_front();
        if (out_item.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item.status); errors++;
        end
        if (out_item.item_value !== e.item_value) begin
          $error("item_value exp %0d got %0d", e.item_value, out_item.item_value);
          errors++;
        end
        if (out_item.item_position !== e.item_position) begin
          $error("item_position exp %0d got %0d", e.item_position, out_item.item_position);
          errors++;
        end
        if (out_item.node_count !== e.node_count) begin
          $error("node_count exp %0d got %0d", e.node_count, out_item.node_count);
          errors++;
        end
        if (out_item.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_item.last); errors++;
        end
      end
    end
  end

  initial begin
    pll_in_t c;
    int phase_items;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      c.cmd = directed_steps[i].cmd;
      c.position = directed_steps[i].pos;
      c.new_value = directed_steps[i].val;
      send_cmd(c);
      // typed rows pin the status read straight off the command
      if (directed_steps[i].typed && pending_results[$].status !== directed_steps[i].st) begin
        $error("status exp %0d got %0d (table)", directed_steps[i].st,
               pending_results[$].status);
        errors++;
      end
    end

    // fill to capacity, then probe the full case and a long receiver hold-off
    while (list_vals.size() < CAP) begin
      c.cmd = CMD_INSERT;
      c.position = POS_W'($urandom_range(list_vals.size() + 1, 1));
      c.new_value = $urandom;
      send_cmd(c);
    end
    c.cmd = CMD_INSERT; c.position = 7'd1; c.new_value = 32'h1234;
    send_cmd(c);
    hold_off = 300;
    c.cmd = CMD_DUMP;
    send_cmd(c);
    send_cmd(c);
    c.cmd = CMD_DELETE; c.position = 7'd16;
    send_cmd(c);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 61 : 0;
      recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 24 : 0;
      phase_items = 85;
      for (int i = 0; i < phase_items; i++) send_cmd(rand_cmd());
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered insert/delete/dump with errors, a full list and long output stalls;");
    $display("%0d results checked over %0d cycles.", results_seen, cycles);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
